// ===== src/spq_pkg.sv =====
// Types and constants shared by the sorted-insert priority queue.
`default_nettype none

package spq_pkg;

   localparam int DEPTH    = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KEY_W    = 16;
   localparam int SHIFT_W  = 8;
   localparam int HANDLE_W = 32;
   localparam int OCC_W    = 5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_POP    = 1'b1
   } kind_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [SHIFT_W-1:0]  shift;
      logic [HANDLE_W-1:0] handle;
   } record_type;

   typedef struct packed {
      kind_type            kind;
      logic [KEY_W-1:0]    insert_key;
      logic [SHIFT_W-1:0]  insert_shift;
      logic [HANDLE_W-1:0] insert_name_handle;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_W-1:0]    popped_key;
      logic [SHIFT_W-1:0]  popped_shift;
      logic [HANDLE_W-1:0] popped_name_handle;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // broadcast from the top to every cell
   typedef struct packed {
      logic       insert;
      logic       pop;
      record_type rec;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted shift-register chain.
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          slot_valid,
   input  wire logic          left_cond,
   input  wire record_type    left_slot,
   input  wire record_type    right_slot,
   output logic               cond,
   output record_type         slot
);

   record_type slot_ff, slot_in;

   // new record belongs at or left of this slot
   assign cond = !slot_valid || (slot_ff.key >= ctrl.rec.key);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert) begin
         if (cond) begin
            slot_in = left_cond ? left_slot : ctrl.rec;
         end
      end else if (ctrl.pop) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

// ===== src/sorted_insert_priority_queue_core.sv =====
// Sorted-insert priority queue: top level with the cell chain and result register.
//
// Request channel (req_valid/req_ready/req_data): kind selects insert or pop.
// An insert places its record ahead of the first stored record whose key is
// not smaller; a pop removes the record with the smallest key.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, with status ok, full (insert dropped) or empty (pop found nothing),
// the popped record (zero unless a pop succeeded) and the occupancy after it.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while req_ready is high: every cell
// compares its key with the new key and shifts at that same edge. req_ready
// is high whenever the response register is empty or being taken, so a
// stalled receiver holds the queue only while a response waits.
// Reset empties the queue (count to zero) and drops any waiting response;
// slot contents are not reset and are never read until written.
`default_nettype none

module sorted_insert_priority_queue_core
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             accept, full, empty;
   cell_ctrl_type    ctrl;
   logic [DEPTH-1:0] cond;
   record_type       slots [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.insert     = accept && (req_data.kind == KIND_INSERT) && !full;
   assign ctrl.pop        = accept && (req_data.kind == KIND_POP) && !empty;
   assign ctrl.rec.key    = req_data.insert_key;
   assign ctrl.rec.shift  = req_data.insert_shift;
   assign ctrl.rec.handle = req_data.insert_name_handle;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot_valid (CNT_W'(i) < count_ff),
         .left_cond  ((i == 0) ? 1'b0 : cond[(i == 0) ? 0 : i - 1]),
         .left_slot  ((i == 0) ? ctrl.rec : slots[(i == 0) ? 0 : i - 1]),
         .right_slot ((i == DEPTH - 1) ? slots[i] : slots[(i == DEPTH - 1) ? i : i + 1]),
         .cond       (cond[i]),
         .slot       (slots[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_in.status             = ST_OK;
         rsp_in.popped_key         = '0;
         rsp_in.popped_shift       = '0;
         rsp_in.popped_name_handle = '0;
         if (req_data.kind == KIND_INSERT) begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end
         end else if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.popped_key         = slots[0].key;
            rsp_in.popped_shift       = slots[0].shift;
            rsp_in.popped_name_handle = slots[0].handle;
         end
         rsp_in.occupancy = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.occupancy == OCC_W'(count_ff)))
      else $error("response occupancy differs from count");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_POP && empty) |=>
         (rsp_ff.status == ST_EMPTY && count_ff == '0))
      else $error("pop on empty queue mishandled");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_INSERT && full) |=>
         (rsp_ff.status == ST_FULL && count_ff == CNT_W'(DEPTH)))
      else $error("insert on full queue mishandled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the sorted-insert priority queue: random and directed requests, checked responses.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam int RANDOM_REQS   = 1750;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 120;
   localparam int PRINT_LIMIT   = 40;
   localparam int PHASE_A_END   = 600;
   localparam int PHASE_B_END   = 1200;

   typedef struct {
      req_type req;
      bit      drain;   // wait until every response is back before offering
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_type pending_reqs[$];
   rsp_type     expected_rsps[$];
   record_type  model_slots[DEPTH];
   int          model_count = 0;

   int total_reqs = 0;
   int n_accepted = 0;
   int n_sent = 0;
   int n_recv = 0;
   int n_errors = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int n_inserts = 0, n_pops = 0, n_full_drops = 0, n_empty_pops = 0, n_hit_full = 0;

   sorted_insert_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // sorted insert ahead of equal keys, pop from the head
   function automatic rsp_type predict_queue_step(req_type r);
      rsp_type o;
      int      pos;
      int      i;
      o = '0;
      o.status = ST_OK;
      if (r.kind == KIND_INSERT) begin
         n_inserts++;
         if (model_count >= DEPTH) begin
            o.status = ST_FULL;
            n_full_drops++;
         end else begin
            pos = 0;
            while (pos < model_count && model_slots[pos].key < r.insert_key) pos++;
            for (i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
            model_slots[pos].key    = r.insert_key;
            model_slots[pos].shift  = r.insert_shift;
            model_slots[pos].handle = r.insert_name_handle;
            model_count++;
            if (model_count == DEPTH) n_hit_full++;
         end
      end else begin
         n_pops++;
         if (model_count == 0) begin
            o.status = ST_EMPTY;
            n_empty_pops++;
         end else begin
            o.popped_key         = model_slots[0].key;
            o.popped_shift       = model_slots[0].shift;
            o.popped_name_handle = model_slots[0].handle;
            for (i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
            model_count--;
         end
      end
      o.occupancy = OCC_W'(model_count);
      return o;
   endfunction

   function automatic int idle_pct(int n, bit sender);
      if (n < PHASE_A_END) return sender ? 20 : 73;
      if (n < PHASE_B_END) return sender ? 73 : 20;
      return 0;
   endfunction

   function automatic void add_request(kind_type kind, logic [KEY_W-1:0] key,
                                       logic [SHIFT_W-1:0] shift,
                                       logic [HANDLE_W-1:0] handle, bit drain);
      pending_type p;
      p.req.kind               = kind;
      p.req.insert_key         = key;
      p.req.insert_shift       = shift;
      p.req.insert_name_handle = handle;
      p.drain                  = drain;
      pending_reqs.push_back(p);
      total_reqs++;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(int mode, logic [KEY_W-1:0] base);
      case (mode)
         0: return KEY_W'($urandom_range(0, 3));          // heavy duplicates
         1: return KEY_W'($urandom_range(0, 65535));
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'h0001;
               2: return 16'hFFFE;
               default: return 16'hFFFF;
            endcase
         end
         default: return base + KEY_W'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (n_errors < PRINT_LIMIT)
         $display("%0t ns mismatch %s: got %0h expected %0h", $time, what, got, want);
      n_errors++;
   endtask

   // driver
   always @(posedge clock) begin
      bit      accepted;
      bit      drained;
      rsp_type r;
      accepted = req_valid && req_ready;
      drained  = !req_valid && !rsp_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            r = predict_queue_step(req_data);
            expected_rsps.push_back(r);
            n_accepted <= n_accepted + 1;
         end
         if (!(req_valid && !accepted)) begin
            if (pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(n_sent, 1'b1) &&
                (!pending_reqs[0].drain || drained)) begin
               req_data  <= pending_reqs[0].req;
               req_valid <= 1'b1;
               pending_reqs.pop_front();
               n_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_recv++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no request waiting",
                               32'(rsp_data.status), '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.popped_key !== want.popped_key)
                  report_mismatch("popped_key", 32'(rsp_data.popped_key),
                                  32'(want.popped_key));
               if (rsp_data.popped_shift !== want.popped_shift)
                  report_mismatch("popped_shift", 32'(rsp_data.popped_shift),
                                  32'(want.popped_shift));
               if (rsp_data.popped_name_handle !== want.popped_name_handle)
                  report_mismatch("popped_name_handle", rsp_data.popped_name_handle,
                                  want.popped_name_handle);
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_data.occupancy),
                                  32'(want.occupancy));
            end
            // long receiver stall so the request side backs up
            if (n_recv == 300 || n_recv == 1500) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct(n_recv, 1'b0));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns timeout: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int               n_random;
      int               len;
      int               pct;
      int               mode;
      int               j;
      logic [KEY_W-1:0] base;

      // directed: empty pop, extremes, equal keys, fill to full, drop, pops
      add_request(KIND_POP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      add_request(KIND_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      add_request(KIND_INSERT, 16'h0000, 8'h00, 32'h0000_0000, 1'b0);
      add_request(KIND_INSERT, 16'hFFFF, 8'h5A, 32'hA5A5_A5A5, 1'b0);
      add_request(KIND_INSERT, 16'h8000, 8'h01, 32'h0000_0001, 1'b0);
      add_request(KIND_INSERT, 16'h8000, 8'h02, 32'h0000_0002, 1'b0);
      add_request(KIND_INSERT, 16'h0000, 8'h80, 32'h8000_0000, 1'b0);
      for (j = 0; j < DEPTH - 6; j++)
         add_request(KIND_INSERT, KEY_W'($urandom_range(0, 65535)),
                     SHIFT_W'($urandom_range(0, 255)), $urandom, 1'b0);
      add_request(KIND_INSERT, 16'h1234, 8'hC3, 32'h1234_5678, 1'b0);
      for (j = 0; j < 4; j++)
         add_request(KIND_POP, KEY_W'($urandom_range(0, 65535)),
                     SHIFT_W'($urandom_range(0, 255)), $urandom, 1'b0);

      // random bursts biased toward filling the queue, draining it, or neither
      n_random = 0;
      while (n_random < RANDOM_REQS) begin
         case ($urandom_range(0, 2))
            0: pct = 15;
            1: pct = 50;
            default: pct = 85;
         endcase
         mode = $urandom_range(0, 3);
         base = KEY_W'($urandom_range(0, 65535));
         len  = $urandom_range(8, 40);
         for (j = 0; j < len && n_random < RANDOM_REQS; j++) begin
            add_request(($urandom_range(0, 99) < pct) ? KIND_INSERT : KIND_POP,
                        pick_key(mode, base), SHIFT_W'($urandom_range(0, 255)),
                        $urandom, (n_random % 400) == 0);
            n_random++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (n_accepted != total_reqs || rsp_valid);
      repeat (10) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("responses never returned", expected_rsps.size(), 0);

      $display("covered %0d requests: %0d inserts (%0d dropped as full), %0d pops (%0d on empty)",
               n_accepted, n_inserts, n_full_drops, n_pops, n_empty_pops);
      $display("queue filled %0d times; idle mixes, receiver stalls and drain pauses applied",
               n_hit_full);
      if (n_errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_insert_priority_queue_core.sv
tb/tb_top.sv
